// ===== rtl/core/wnps_pkg.sv =====
// Package for the window nearest point search block.
// Shared constants, register codes and the pipeline tag type; no dependencies.
`default_nettype none

package wnps_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    localparam int PIXEL_W     = 11;   // signed pixel column / row
    localparam int DIM_W       = 8;    // image_width / image_height
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = DIM_W;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 8'd128;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 8'd128;

    // item action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // travels with each window read through the distance pipeline
    typedef struct packed {
        logic valid;   // pixel inside the image (later: and z positive)
        logic last;    // final pixel of the window
    } wnps_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/wnps_if.sv =====
// Item channels of the window nearest point search block.
// Command channel (writes and queries) and result channel; uses wnps_pkg.
`default_nettype none

interface wnps_cmd_if
    import wnps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic signed [PIXEL_W-1:0]   pixel_column;
    logic signed [PIXEL_W-1:0]   pixel_row;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source (output valid, action, pixel_column, pixel_row, coord_x, coord_y, coord_z,
                    input ready);
    modport sink   (input valid, action, pixel_column, pixel_row, coord_x, coord_y, coord_z,
                    output ready);
endinterface

interface wnps_res_if
    import wnps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic signed [COORD_BITS-1:0]  near_x;
    logic signed [COORD_BITS-1:0]  near_y;
    logic signed [COORD_BITS-1:0]  near_z;
    logic [2*COORD_BITS+1:0]       dist_sqr;

    modport source (output valid, found, near_x, near_y, near_z, dist_sqr, input ready);
    modport sink   (input valid, found, near_x, near_y, near_z, dist_sqr, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wnps_dist.sv =====
// Two-stage squared distance unit: z check and squares, then the sum.
// Uses wnps_pkg for the tag type.
`default_nettype none

module wnps_dist
    import wnps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wnps_tag_t                     tag_in,
    input  wire logic [3*COORD_BITS-1:0]       point_in,   // {z, y, x}
    input  wire logic signed [COORD_BITS-1:0]  qx,
    input  wire logic signed [COORD_BITS-1:0]  qy,
    input  wire logic signed [COORD_BITS-1:0]  qz,
    output wnps_tag_t                          tag_out,
    output logic [3*COORD_BITS-1:0]            point_out,
    output logic [2*COORD_BITS+1:0]            dist_out
);

    localparam int MW = COORD_BITS + 1;
    localparam int DW = 2 * COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] px, py, pz;
    logic signed [MW-1:0]         dx, dy, dz;
    logic [MW-1:0]                mag_x, mag_y, mag_z;
    logic                         z_pos;

    wnps_tag_t                    tag2_reg, tag2_next;
    logic [DW-1:0]                sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DW-1:0]                sq_x_next, sq_y_next, sq_z_next;
    logic [3*COORD_BITS-1:0]      point2_reg;

    wnps_tag_t                    tag3_reg;
    logic [DW-1:0]                dist3_reg, dist3_next;
    logic [3*COORD_BITS-1:0]      point3_reg;

    always_comb
    begin
        px = point_in[COORD_BITS-1:0];
        py = point_in[2*COORD_BITS-1:COORD_BITS];
        pz = point_in[3*COORD_BITS-1:2*COORD_BITS];
        dx = {qx[COORD_BITS-1], qx} - {px[COORD_BITS-1], px};
        dy = {qy[COORD_BITS-1], qy} - {py[COORD_BITS-1], py};
        dz = {qz[COORD_BITS-1], qz} - {pz[COORD_BITS-1], pz};
        // magnitude of the most negative difference is 2^COORD_BITS-1, correct unsigned
        mag_x = dx[MW-1] ? MW'(-dx) : MW'(dx);
        mag_y = dy[MW-1] ? MW'(-dy) : MW'(dy);
        mag_z = dz[MW-1] ? MW'(-dz) : MW'(dz);
        sq_x_next = mag_x * mag_x;
        sq_y_next = mag_y * mag_y;
        sq_z_next = mag_z * mag_z;
        z_pos = !pz[COORD_BITS-1] && (pz != '0);
        tag2_next.valid = tag_in.valid && z_pos;
        tag2_next.last  = tag_in.last;
        // three squares below 2^(2*COORD_BITS) each: the sum fits DW bits
        dist3_next = sq_x_reg + sq_y_reg + sq_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag2_reg <= tag2_next;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg   <= sq_x_next;
        sq_y_reg   <= sq_y_next;
        sq_z_reg   <= sq_z_next;
        point2_reg <= point_in;
        dist3_reg  <= dist3_next;
        point3_reg <= point2_reg;
    end

    assign tag_out   = tag3_reg;
    assign point_out = point3_reg;
    assign dist_out  = dist3_reg;

endmodule

`default_nettype wire

// ===== rtl/core/window_nearest_point_search.sv =====
// Top level of the window nearest point search block: point store,
// window scan sequencer, best-point tracking and result register.
// Depends on wnps_pkg, wnps_if (wnps_cmd_if, wnps_res_if) and wnps_dist.
`default_nettype none

//  channel  | dir | payload                                            | handshake
//  ---------+-----+----------------------------------------------------+-------------
//  cmd      | in  | action, pixel_column, pixel_row, coord_x/y/z       | valid/ready
//  res      | out | found, near_x/y/z, dist_sqr                        | valid/ready
//  cfg      | in  | cfg_index, cfg_data (image_width, image_height)    | cfg_we only
//
//  A write item is stored in the cycle it is accepted. A query holds cmd
//  ready low after acceptance: nine window reads through the single store
//  port, then the read register and distance pipeline and the result load,
//  so a new query is accepted only after the last one is done.
//  Reset clears control and sets both image sizes to 128; the point store
//  is not cleared and must be written before it is queried.
//  A pending result does not block cmd; a query that finishes while the
//  result register is still full waits until res is taken.

module window_nearest_point_search
    import wnps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    wnps_cmd_if.sink                    cmd,
    wnps_res_if.source                  res,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int PW      = 3 * COORD_BITS;
    localparam int DW      = 2 * COORD_BITS + 2;
    localparam int CLAMP_W = (MAX_WIDTH  < 255) ? MAX_WIDTH  : 255;
    localparam int CLAMP_H = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;

    // latched query
    logic signed [PIXEL_W-1:0]    q_col_reg, q_row_reg;
    logic signed [COORD_BITS-1:0] q_x_reg, q_y_reg, q_z_reg;

    // window position: column offset outer, row offset inner, 0..2 means -1..+1
    logic [1:0] dc_reg, dc_next, dr_reg, dr_next;
    logic       scan_last;

    // shared address path for writes and window reads
    logic signed [PIXEL_W-1:0] base_col, base_row;
    logic [1:0]                off_col, off_row;
    logic signed [PIXEL_W:0]   c, r;
    logic                      in_image;
    logic [ADDR_W-1:0]         addr;

    // point store
    logic [PW-1:0]     store_mem [DEPTH];
    logic [PW-1:0]     rd_data_reg;
    logic              mem_we, mem_re;
    wnps_tag_t         rd_tag_reg, rd_tag_next;

    // distance pipeline result
    wnps_tag_t         d_tag;
    logic [PW-1:0]     d_point;
    logic [DW-1:0]     d_dist;

    // running best
    logic              found_reg, found_next;
    logic [DW-1:0]     best_dist_reg;
    logic [PW-1:0]     best_point_reg;
    logic              take_best;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg;
    logic [DW-1:0]     out_dist_reg;
    logic [PW-1:0]     out_point_reg;
    logic              out_load;

    logic              cmd_take, query_take;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_take   = cmd.valid && cmd.ready;
    assign query_take = cmd_take && (cmd.action == ACT_QUERY);

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign eff_w = (width_reg  > DIM_W'(CLAMP_W)) ? DIM_W'(CLAMP_W) : width_reg;
    assign eff_h = (height_reg > DIM_W'(CLAMP_H)) ? DIM_W'(CLAMP_H) : height_reg;

    // offset 1 selects the pixel itself (used for writes)
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            base_col = q_col_reg;
            base_row = q_row_reg;
            off_col  = dc_reg;
            off_row  = dr_reg;
        end
        else
        begin
            base_col = cmd.pixel_column;
            base_row = cmd.pixel_row;
            off_col  = 2'd1;
            off_row  = 2'd1;
        end
        c = {base_col[PIXEL_W-1], base_col} + $signed({{(PIXEL_W-1){1'b0}}, off_col})
            - $signed((PIXEL_W+1)'(1));
        r = {base_row[PIXEL_W-1], base_row} + $signed({{(PIXEL_W-1){1'b0}}, off_row})
            - $signed((PIXEL_W+1)'(1));
        in_image = !c[PIXEL_W] && (c[PIXEL_W-1:0] < PIXEL_W'(eff_w))
                && !r[PIXEL_W] && (r[PIXEL_W-1:0] < PIXEL_W'(eff_h));
        addr = ADDR_W'(r[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c[COL_W-1:0]);
    end

    assign mem_we = cmd_take && (cmd.action == ACT_WRITE) && in_image;
    assign mem_re = (state_reg == ST_SCAN) && in_image;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[addr] <= {cmd.coord_z, cmd.coord_y, cmd.coord_x};
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[addr];
        end
    end

    assign scan_last = (dc_reg == 2'd2) && (dr_reg == 2'd2);

    always_comb
    begin
        rd_tag_next.valid = mem_re;
        rd_tag_next.last  = (state_reg == ST_SCAN) && scan_last;
    end

    wnps_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (rd_tag_reg),
        .point_in  (rd_data_reg),
        .qx        (q_x_reg),
        .qy        (q_y_reg),
        .qz        (q_z_reg),
        .tag_out   (d_tag),
        .point_out (d_point),
        .dist_out  (d_dist)
    );

    // strict less-than keeps the first point on a tie
    assign take_best = d_tag.valid && (!found_reg || (d_dist < best_dist_reg));

    always_comb
    begin
        found_next = found_reg;
        if (query_take)
        begin
            found_next = 1'b0;
        end
        else if (take_best)
        begin
            found_next = 1'b1;
        end
    end

    // sequencer
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        dc_next    = dc_reg;
        dr_next    = dr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                dc_next = 2'd0;
                dr_next = 2'd0;
                if (query_take)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (dr_reg == 2'd2)
                begin
                    dr_next = 2'd0;
                    dc_next = dc_reg + 2'd1;
                end
                else
                begin
                    dr_next = dr_reg + 2'd1;
                end
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (d_tag.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dc_reg        <= 2'd0;
            dr_reg        <= 2'd0;
            rd_tag_reg    <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dc_reg        <= dc_next;
            dr_reg        <= dr_next;
            rd_tag_reg    <= rd_tag_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (query_take)
        begin
            q_col_reg <= cmd.pixel_column;
            q_row_reg <= cmd.pixel_row;
            q_x_reg   <= cmd.coord_x;
            q_y_reg   <= cmd.coord_y;
            q_z_reg   <= cmd.coord_z;
        end
        if (take_best)
        begin
            best_dist_reg  <= d_dist;
            best_point_reg <= d_point;
        end
        if (out_load)
        begin
            out_found_reg <= found_reg;
            out_dist_reg  <= found_reg ? best_dist_reg : '0;
            out_point_reg <= found_reg ? best_point_reg : '0;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.found    = out_found_reg;
    assign res.near_x   = out_point_reg[COORD_BITS-1:0];
    assign res.near_y   = out_point_reg[2*COORD_BITS-1:COORD_BITS];
    assign res.near_z   = out_point_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign res.dist_sqr = out_dist_reg;

    // store is written only between queries
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("point store written during a query");

    // window offsets never reach their unused code while scanning
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (dc_reg != 2'd3) && (dr_reg != 2'd3))
        else $error("window offset out of range");

    // a new query starts with no best point
    a_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
        query_take |=> !found_reg)
        else $error("best point not cleared at query start");

    // an empty result carries zero payload
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_dist_reg == '0) && (out_point_reg == '0))
        else $error("empty result with nonzero payload");

    // the last window tag reaches the compare stage only while draining
    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        d_tag.last |-> (state_reg == ST_DRAIN))
        else $error("window end seen outside drain");

endmodule

`default_nettype wire
